### hdl/ddb_pkg.sv
// ----------------------------------------------------------------------------
// ddb_pkg - shared types and constants of the directed graph degree builder
// Field widths, item mode codes, queue command format and status structs.
// ----------------------------------------------------------------------------
package ddb_pkg;

    localparam int VERTICES_DEF = 64;
    localparam int MODE_W       = 2;
    localparam int VERTEX_W     = 6;
    localparam int CNT_W        = 7;
    localparam int EDGE_W       = 13;
    localparam int TOT_W        = 8;
    localparam int QDEPTH       = 2;

    localparam logic [EDGE_W-1:0] EDGE_MAX = 13'd8191;

    localparam logic [MODE_W-1:0] MODE_PATH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_EDGE,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VERTEX_W-1:0] vertex;
    } in_t;

    typedef struct packed {
        logic                new_edge;
        logic [EDGE_W-1:0]   edge_count;
        logic [VERTEX_W-1:0] highest_vertex;
        logic [CNT_W-1:0]    out_degree;
        logic [CNT_W-1:0]    in_degree;
        logic [TOT_W-1:0]    total_degree;
    } out_t;

    typedef struct packed {
        op_t                 op;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        logic [VERTEX_W-1:0] highest;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef struct packed {
        logic valid;
        logic full;
        cmd_t head;
    } queue_status_t;

endpackage

### hdl/ddb_front.sv
// ----------------------------------------------------------------------------
// ddb_front - item classifier
// Tracks the open path and the highest vertex, and turns each accepted
// transaction into one command for the execution side.
// ----------------------------------------------------------------------------
module ddb_front #(
    parameter int VERTICES = ddb_pkg::VERTICES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  ddb_pkg::in_t item,
    output logic         push,
    output ddb_pkg::cmd_t cmd
);
    import ddb_pkg::*;

    logic [VERTEX_W-1:0] prev_reg, prev_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [VERTEX_W-1:0] highest_reg, highest_next;
    logic                in_range;

    assign in_range = 32'(item.vertex) < VERTICES;

    always_comb
    begin
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        highest_next    = highest_reg;
        cmd.op          = OP_NONE;
        cmd.src         = item.vertex;
        cmd.dst         = item.vertex;
        unique case (item.mode)
            MODE_PATH:
            begin
                if (in_range)
                begin
                    if (item.vertex > highest_reg)
                        highest_next = item.vertex;
                    if (prev_valid_reg)
                    begin
                        cmd.op  = OP_EDGE;
                        cmd.src = prev_reg;
                    end
                    prev_next       = item.vertex;
                    prev_valid_next = 1'b1;
                end
            end
            MODE_END:
                prev_valid_next = 1'b0;
            MODE_QUERY:
            begin
                if (in_range)
                    cmd.op = OP_QUERY;
            end
            default:
                cmd.op = OP_NONE;
        endcase
        cmd.highest = highest_next;
    end

    assign push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            highest_reg    <= '0;
        end
        else if (accept)
        begin
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            highest_reg    <= highest_next;
        end
    end

endmodule

### hdl/ddb_queue.sv
// ----------------------------------------------------------------------------
// ddb_queue - command queue
// Short first-in first-out buffer between the classifier and execution.
// ----------------------------------------------------------------------------
module ddb_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ddb_pkg::cmd_t          cmd,
    input  logic                   pop,
    output ddb_pkg::queue_status_t status
);
    import ddb_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    cmd_t                entry_reg [QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.valid = count_reg != '0;
    assign status.full  = count_reg == CNT_QW'(QDEPTH);
    assign status.head  = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_QW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_QW'(1);
    end

    // Wrap the pointers at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= cmd;
    end

endmodule

### hdl/ddb_back.sv
// ----------------------------------------------------------------------------
// ddb_back - command execution
// Holds the adjacency rows and degree counters, clears them after reset,
// reads them for each edge or query command and writes them back for a new edge.
// ----------------------------------------------------------------------------
module ddb_back #(
    parameter int VERTICES = ddb_pkg::VERTICES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ddb_pkg::cmd_t         q_head,
    output logic                  q_pop,
    output ddb_pkg::back_status_t status,
    output logic                  result_valid,
    output ddb_pkg::out_t         result
);
    import ddb_pkg::*;

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    logic [VERTICES-1:0] edge_mem [VERTICES];
    logic [CNT_W-1:0]    out_mem  [VERTICES];
    logic [CNT_W-1:0]    in_mem   [VERTICES];

    back_state_t         state_reg, state_next;
    logic [VW-1:0]       clr_idx_reg;
    cmd_t                cmd_reg, cmd_next;
    logic [EDGE_W-1:0]   edge_total_reg, edge_total_next;
    logic                result_valid_reg, result_valid_next;
    out_t                result_reg, result_next;

    logic [VERTICES-1:0] row_reg;
    logic [CNT_W-1:0]    out_cnt_reg, in_cnt_reg;

    logic                rd_en;
    logic [VW-1:0]       rd_src, rd_dst;
    logic [VW-1:0]       ex_src, ex_dst;
    logic                upd_en, clr_en;
    logic [VW-1:0]       wr_row, wr_out, wr_in;
    logic [VERTICES-1:0] row_wdata;
    logic                edge_hit;

    assign rd_src   = VW'(q_head.src);
    assign rd_dst   = VW'(q_head.dst);
    assign ex_src   = VW'(cmd_reg.src);
    assign ex_dst   = VW'(cmd_reg.dst);
    assign edge_hit = row_reg[ex_dst];
    assign clr_en   = state_reg == BK_CLEAR;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        edge_total_next   = edge_total_reg;
        result_valid_next = 1'b0;
        result_next       = '0;
        result_next.edge_count = edge_total_reg;
        q_pop             = 1'b0;
        rd_en             = 1'b0;
        upd_en            = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                if (clr_idx_reg == VW'(VERTICES - 1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.op == OP_NONE)
                    begin
                        result_valid_next          = 1'b1;
                        result_next.highest_vertex = q_head.highest;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        cmd_next   = q_head;
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_EXEC:
            begin
                result_valid_next          = 1'b1;
                result_next.highest_vertex = cmd_reg.highest;
                if (cmd_reg.op == OP_EDGE)
                begin
                    if (!edge_hit)
                    begin
                        upd_en = 1'b1;
                        if (edge_total_reg != EDGE_MAX)
                            edge_total_next = edge_total_reg + EDGE_W'(1);
                        result_next.new_edge = 1'b1;
                    end
                    result_next.edge_count = edge_total_next;
                end
                else
                begin
                    result_next.out_degree   = out_cnt_reg;
                    result_next.in_degree    = in_cnt_reg;
                    result_next.total_degree = TOT_W'(out_cnt_reg) + TOT_W'(in_cnt_reg);
                end
                state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // The clearing sweep and the update share one write port per memory
    assign wr_row    = clr_en ? clr_idx_reg : ex_src;
    assign wr_out    = clr_en ? clr_idx_reg : ex_src;
    assign wr_in     = clr_en ? clr_idx_reg : ex_dst;
    assign row_wdata = clr_en ? '0
                              : (row_reg | ({{(VERTICES-1){1'b0}}, 1'b1} << ex_dst));

    always_ff @(posedge clk)
    begin
        if (clr_en || upd_en)
            edge_mem[wr_row] <= row_wdata;
        if (rd_en)
            row_reg <= edge_mem[rd_src];
    end

    always_ff @(posedge clk)
    begin
        if (clr_en || upd_en)
            out_mem[wr_out] <= clr_en ? '0 : out_cnt_reg + CNT_W'(1);
        if (rd_en)
            out_cnt_reg <= out_mem[rd_src];
    end

    always_ff @(posedge clk)
    begin
        if (clr_en || upd_en)
            in_mem[wr_in] <= clr_en ? '0 : in_cnt_reg + CNT_W'(1);
        if (rd_en)
            in_cnt_reg <= in_mem[rd_dst];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_CLEAR;
            clr_idx_reg      <= '0;
            edge_total_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            edge_total_reg   <= edge_total_next;
            result_valid_reg <= result_valid_next;
            if (clr_en)
                clr_idx_reg <= clr_idx_reg + VW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    assign status.clearing = clr_en;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

endmodule

### hdl/directed_graph_degree_builder.sv
// ----------------------------------------------------------------------------
// directed_graph_degree_builder - adjacency matrix with degree counts
// Edge and query items pass the queue, the row and counter read registers and
//   the result register, other items the queue and result register; each
//   accepted transaction gives one result. An edge or query command holds the
//   back side for its read-modify-write; other items one per cycle otherwise.
// Reset: a clearing pass over all VERTICES rows follows reset, busy held high.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module directed_graph_degree_builder #(
    parameter int VERTICES = ddb_pkg::VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ddb_pkg::in_t  item,
    output logic          result_valid,
    output ddb_pkg::out_t result
);
    import ddb_pkg::*;

    // Front side: classify each transaction, keep the open path and the
    // highest vertex, hand one command per transaction to the queue.
    logic          accept;
    logic          push;
    cmd_t          cmd;
    queue_status_t q_status;
    logic          q_pop;
    back_status_t  back_status;

    // Hold off new transactions while the memories clear or the queue fills
    assign busy   = back_status.clearing || q_status.full;
    assign accept = start && !busy;

    ddb_front #(
        .VERTICES (VERTICES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .cmd    (cmd)
    );

    // Queue parts the two sides so each stalls on its own
    ddb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .cmd    (cmd),
        .pop    (q_pop),
        .status (q_status)
    );

    // Back side: adjacency rows, degree counters, edge total and result register
    ddb_back #(
        .VERTICES (VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_status.valid),
        .q_head       (q_status.head),
        .q_pop        (q_pop),
        .status       (back_status),
        .result_valid (result_valid),
        .result       (result)
    );

    // No result may leave while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.clearing |-> !result_valid)
        else $error("result during clearing pass");

    // A new edge result carries no degree figures
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.new_edge |->
            result.out_degree == '0 && result.in_degree == '0)
        else $error("new edge result with degree fields");

    // Total degree is the sum of the two degree fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.total_degree == TOT_W'(result.out_degree) + TOT_W'(result.in_degree))
        else $error("total degree mismatch");

    // The edge count never falls between consecutive results
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && $past(result_valid) |->
            result.edge_count >= $past(result.edge_count))
        else $error("edge count fell");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the directed graph degree builder
// Path, end-of-path, query and unused-mode transactions are queued up front,
// driven through the start/busy handshake with random sender gaps, and every
// strobed result is checked field by field against a graph shadow kept here.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ddb_pkg::*;

    localparam int NV            = VERTICES_DEF;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 550;

    // Mode code the block has no use for; it must leave all state alone
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        in_t         txn;
        int unsigned idle_pct;
        bit          drain_first;
    } pend_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  item = '0;
    logic result_valid;
    out_t result;

    pend_t pend_q [$];
    out_t  degree_q [$];

    // Graph shadow: adjacency bits, degree counters, open-path tracking
    bit              adj [NV][NV];
    bit [CNT_W-1:0]  out_deg [NV];
    bit [CNT_W-1:0]  in_deg [NV];
    bit [EDGE_W-1:0] edge_total;
    bit [VERTEX_W-1:0] path_tail;
    bit              path_open;
    bit [VERTEX_W-1:0] top_vertex;

    // Stimulus build state
    int unsigned gen_idle;
    bit          gen_drain;
    int unsigned live_cnt;
    int unsigned hub;

    int unsigned fail_cnt;
    int unsigned cycle_cnt;

    directed_graph_degree_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted transaction to the shadow graph and
    // return the result it must produce.
    // ------------------------------------------------------------------------
    function automatic out_t graph_apply(in_t it);
        out_t r;
        r = '0;
        case (it.mode)
            MODE_PATH:
            begin
                if (it.vertex > top_vertex)
                    top_vertex = it.vertex;
                // The first vertex of a path only opens it; a repeated edge
                // counts nothing
                if (path_open && !adj[path_tail][it.vertex])
                begin
                    adj[path_tail][it.vertex] = 1'b1;
                    if (edge_total != EDGE_MAX)
                        edge_total++;
                    out_deg[path_tail]++;
                    in_deg[it.vertex]++;
                    r.new_edge = 1'b1;
                end
                path_tail = it.vertex;
                path_open = 1'b1;
            end
            MODE_END:
                path_open = 1'b0;
            MODE_QUERY:
            begin
                // Queries leave the open path untouched
                r.out_degree   = out_deg[it.vertex];
                r.in_degree    = in_deg[it.vertex];
                r.total_degree = {1'b0, out_deg[it.vertex]} + {1'b0, in_deg[it.vertex]};
            end
            default: ;
        endcase
        r.edge_count     = edge_total;
        r.highest_vertex = top_vertex;
        return r;
    endfunction

    task automatic report_fail(string msg);
        $display("%0t ns: %s", $time, msg);
        fail_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    task automatic push_item(logic [MODE_W-1:0] m, int unsigned v);
        pend_t p;
        p.txn.mode    = m;
        p.txn.vertex  = v[VERTEX_W-1:0];
        p.idle_pct    = gen_idle;
        p.drain_first = gen_drain;
        gen_drain     = 1'b0;
        pend_q.insert(pend_q.size(), p);
        // Ignored transactions do not count towards the stimulus volume
        if (m != MODE_UNUSED)
            live_cnt++;
    endtask

    // Favour a small set of vertices half the time so edges repeat
    function automatic int unsigned pick_vertex();
        return $urandom_range(1) ? $urandom_range(15) : $urandom_range(NV - 1);
    endfunction

    task automatic add_burst();
        int unsigned kind;
        int unsigned len;
        bit          hub_path;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            // Well-formed path; hub paths alternate the hub with other vertices
            // so that the hub's in- and out-degree climb towards their limit
            hub_path = ($urandom_range(9) < 3);
            len      = $urandom_range(10, 1);
            for (int i = 0; i < len; i++)
            begin
                push_item(MODE_PATH, (hub_path && i % 2 == 0) ? hub : pick_vertex());
                if ($urandom_range(9) == 0)
                    push_item(MODE_QUERY, pick_vertex());
            end
            // Leave some paths open so the next one chains on
            if ($urandom_range(99) < 85)
                push_item(MODE_END, $urandom_range(NV - 1));
        end
        else if (kind < 85)
            push_item(MODE_QUERY, ($urandom_range(3) == 0) ? hub : $urandom_range(NV - 1));
        else if (kind < 93)
            push_item(MODE_END, $urandom_range(NV - 1));
        else
            push_item(MODE_UNUSED, $urandom_range(NV - 1));
    endtask

    initial
    begin
        int unsigned idle_pct [3];
        idle_pct[0] = 7;
        idle_pct[1] = 51;
        idle_pct[2] = 0;
        hub         = $urandom_range(NV - 1);

        // Directed part: empty graph, extremes, self-loop, repeats, stray
        // ends, queries inside an open path and the unused mode
        gen_idle = idle_pct[0];
        push_item(MODE_QUERY, 0);
        push_item(MODE_END, NV - 1);
        push_item(MODE_PATH, 0);
        push_item(MODE_PATH, NV - 1);
        push_item(MODE_PATH, NV - 1);
        push_item(MODE_END, 0);
        push_item(MODE_PATH, 0);
        push_item(MODE_PATH, NV - 1);
        push_item(MODE_QUERY, NV - 1);
        push_item(MODE_PATH, 0);
        push_item(MODE_END, 0);
        push_item(MODE_END, NV - 1);
        push_item(MODE_UNUSED, NV - 1);
        push_item(MODE_UNUSED, 0);
        push_item(MODE_QUERY, NV - 1);
        push_item(MODE_QUERY, 0);
        push_item(MODE_PATH, 42);
        push_item(MODE_PATH, 21);
        push_item(MODE_PATH, 42);
        push_item(MODE_END, 21);
        push_item(MODE_QUERY, 42);
        push_item(MODE_QUERY, 21);

        // Random part in three idling phases; drain before each one
        for (int ph = 0; ph < 3; ph++)
        begin
            gen_idle  = idle_pct[ph];
            gen_drain = 1'b1;
            while (live_cnt < 22 + (ph + 1) * PHASE_ITEMS)
                add_burst();
        end

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pend_q.size() != 0 || start || degree_q.size() != 0)
            @(posedge clk);
        // Let any stray late strobe show up before deciding
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && degree_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: record an accepted transaction, then present the next one or
    // drop start. Hold everything while busy stalls a pending transaction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        pend_t nxt;
        bit    go;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
                degree_q.insert(degree_q.size(), graph_apply(item));
            go = 1'b0;
            if (pend_q.size() != 0)
            begin
                nxt = pend_q[0];
                go  = ($urandom_range(99) >= nxt.idle_pct);
                // Pause until every outstanding result has been seen
                if (nxt.drain_first && degree_q.size() != 0)
                    go = 1'b0;
            end
            if (go)
            begin
                void'(pend_q.pop_front());
                start <= 1'b1;
                item  <= nxt.txn;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each strobe is one result transaction; match it to the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        out_t want;
        if (rst_n && result_valid)
        begin
            if (degree_q.size() == 0)
                report_fail($sformatf("result with nothing predicted: %h", result));
            else
            begin
                want = degree_q.pop_front();
                if (result.new_edge !== want.new_edge)
                    report_fail($sformatf("new_edge %0d, predicted %0d",
                                          result.new_edge, want.new_edge));
                if (result.edge_count !== want.edge_count)
                    report_fail($sformatf("edge_count %0d, predicted %0d",
                                          result.edge_count, want.edge_count));
                if (result.highest_vertex !== want.highest_vertex)
                    report_fail($sformatf("highest_vertex %0d, predicted %0d",
                                          result.highest_vertex, want.highest_vertex));
                if (result.out_degree !== want.out_degree)
                    report_fail($sformatf("out_degree %0d, predicted %0d",
                                          result.out_degree, want.out_degree));
                if (result.in_degree !== want.in_degree)
                    report_fail($sformatf("in_degree %0d, predicted %0d",
                                          result.in_degree, want.in_degree));
                if (result.total_degree !== want.total_degree)
                    report_fail($sformatf("total_degree %0d, predicted %0d",
                                          result.total_degree, want.total_degree));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

### files.f
hdl/ddb_pkg.sv
hdl/ddb_front.sv
hdl/ddb_queue.sv
hdl/ddb_back.sv
hdl/directed_graph_degree_builder.sv
sim/tb_top.sv
